@@ design/cefd_pkg.sv @@
// Shared constants and types for the credit event frame decoder.
// Depends on nothing; the front, queue, back and top refer to it by scoped names.
package cefd_pkg;

   localparam int StoreBase  = 4;    // frame offset of the event counter byte
   localparam int StoreDepth = 11;   // offsets 4..14 are kept
   localparam int PairBytes  = StoreDepth - 1;
   localparam int MaxEvents  = 5;    // cap on events reported per frame
   localparam int CountW     = $clog2(MaxEvents + 1);
   localparam int PosW       = 4;
   localparam int PosMax     = (1 << PosW) - 1;
   localparam int QueueDepth = 2;
   localparam int QueueAw    = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;

   // One decoded frame, handed from the front to the back.
   typedef struct packed {
      logic                          reset_frame;
      logic [CountW-1:0]             n_events;
      logic [PairBytes-1:0][7:0]     pairs;      // offsets 5..14, credit then code
   } job_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

@@ design/cefd_req_if.sv @@
// Byte channel into the decoder: valid/ready handshake with frame byte and end marker.
// Depends on nothing.
interface cefd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] frame_byte;
   logic       frame_end;

   modport source (output valid, output frame_byte, output frame_end, input ready);
   modport sink   (input valid, input frame_byte, input frame_end, output ready);
endinterface

@@ design/cefd_rsp_if.sv @@
// Result channel out of the decoder: valid/ready handshake with one event per transfer.
// Depends on nothing.
interface cefd_rsp_if;
   logic       valid;
   logic       ready;
   logic       is_error;
   logic [7:0] value;
   logic       reset_seen;
   logic       last_of_run;

   modport source (output valid, output is_error, output value, output reset_seen,
                   output last_of_run, input ready);
   modport sink   (input valid, input is_error, input value, input reset_seen,
                   input last_of_run, output ready);
endinterface

@@ design/cefd_front.sv @@
// Front end: takes frame bytes, keeps the counter and pair bytes, works out the
// new event count at frame end and pushes a job. Depends on cefd_pkg, cefd_req_if.
module cefd_front (
   input  logic                       clock,
   input  logic                       reset,
   cefd_req_if.sink                   req_ch,
   input  cefd_pkg::queue_status_type q_status,
   output logic                       push,
   output cefd_pkg::job_type          push_job
);

   logic [cefd_pkg::PosW-1:0] pos_ff, pos_in;
   logic [7:0]                ec_ff, ec_in;
   logic                      rp_ff, rp_in;
   logic [7:0]                store_ff [cefd_pkg::StoreDepth];
   logic [7:0]                store_in [cefd_pkg::StoreDepth];
   logic                      accept;
   logic                      frame_done;
   logic [7:0]                newc;
   logic [7:0]                diff;
   logic [7:0]                count8;
   logic [cefd_pkg::CountW-1:0] capped;
   logic                      reset_frame;

   assign req_ch.ready = !q_status.full;
   assign accept       = req_ch.valid && req_ch.ready;
   assign frame_done   = accept && req_ch.frame_end;

   // clear the store on the first byte of a frame, then drop the byte in place
   always_comb begin
      for (int i = 0; i < cefd_pkg::StoreDepth; i++) begin
         store_in[i] = (pos_ff == '0) ? 8'h00 : store_ff[i];
         if (pos_ff == cefd_pkg::PosW'(cefd_pkg::StoreBase + i))
            store_in[i] = req_ch.frame_byte;
      end
   end

   always_comb begin
      if (accept) begin
         if (req_ch.frame_end)
            pos_in = '0;
         else if (pos_ff == cefd_pkg::PosW'(cefd_pkg::PosMax))
            pos_in = pos_ff;
         else
            pos_in = pos_ff + cefd_pkg::PosW'(1);
      end else begin
         pos_in = pos_ff;
      end
   end

   assign newc = store_in[0];
   assign diff = newc - ec_ff;

   always_comb begin
      count8      = 8'h00;
      ec_in       = ec_ff;
      rp_in       = rp_ff;
      reset_frame = 1'b0;
      if (frame_done) begin
         ec_in = newc;
         priority if (newc == 8'h00) begin
            if (ec_ff != 8'h00) begin
               rp_in       = 1'b1;
               reset_frame = 1'b1;
            end
         end else if (ec_ff == 8'h00) begin
            if (rp_ff) begin
               count8 = newc;
               rp_in  = 1'b0;
            end
         end else if (ec_ff < newc) begin
            count8 = diff;
         end else if (ec_ff > newc) begin
            // wrap skips zero
            count8 = diff - 8'h01;
         end else begin
            count8 = 8'h00;
         end
      end
   end

   assign capped = (count8 > 8'(cefd_pkg::MaxEvents))
                   ? cefd_pkg::CountW'(cefd_pkg::MaxEvents)
                   : count8[cefd_pkg::CountW-1:0];

   always_comb begin
      push_job.reset_frame = reset_frame;
      push_job.n_events    = reset_frame ? cefd_pkg::CountW'(1) : capped;
      for (int j = 0; j < cefd_pkg::PairBytes; j++)
         push_job.pairs[j] = store_in[j + 1];
   end

   assign push = frame_done && (reset_frame || (capped != '0));

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
         ec_ff  <= 8'h00;
         rp_ff  <= 1'b0;
      end else begin
         pos_ff <= pos_in;
         ec_ff  <= ec_in;
         rp_ff  <= rp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         for (int i = 0; i < cefd_pkg::StoreDepth; i++)
            store_ff[i] <= store_in[i];
      end
   end

endmodule

@@ design/cefd_queue.sv @@
// Short job queue between front and back, so each side can stall on its own.
// Depends on cefd_pkg.
module cefd_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  cefd_pkg::job_type          push_job,
   input  logic                       pop,
   output cefd_pkg::job_type          head,
   output cefd_pkg::queue_status_type q_status
);

   cefd_pkg::job_type              mem_ff [cefd_pkg::QueueDepth];
   logic [cefd_pkg::QueueAw-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [cefd_pkg::QueueAw-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [cefd_pkg::QueueAw:0]     cnt_ff, cnt_in;

   assign q_status.full  = (cnt_ff == (cefd_pkg::QueueAw + 1)'(cefd_pkg::QueueDepth));
   assign q_status.empty = (cnt_ff == '0);
   assign head           = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push)
         wr_ptr_in = (wr_ptr_ff == cefd_pkg::QueueAw'(cefd_pkg::QueueDepth - 1))
                     ? '0 : wr_ptr_ff + cefd_pkg::QueueAw'(1);
      if (pop)
         rd_ptr_in = (rd_ptr_ff == cefd_pkg::QueueAw'(cefd_pkg::QueueDepth - 1))
                     ? '0 : rd_ptr_ff + cefd_pkg::QueueAw'(1);
      if (push && !pop)
         cnt_in = cnt_ff + (cefd_pkg::QueueAw + 1)'(1);
      else if (pop && !push)
         cnt_in = cnt_ff - (cefd_pkg::QueueAw + 1)'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push)
         mem_ff[wr_ptr_ff] <= push_job;
   end

endmodule

@@ design/cefd_back.sv @@
// Back end: walks the head job one event per cycle, unless the result is stalled, into the result register.
// Depends on cefd_pkg, cefd_rsp_if.
module cefd_back (
   input  logic                       clock,
   input  logic                       reset,
   input  cefd_pkg::job_type          head,
   input  cefd_pkg::queue_status_type q_status,
   output logic                       pop,
   cefd_rsp_if.source                 rsp_ch
);

   logic [cefd_pkg::CountW-1:0] k_ff, k_in, k_next;
   logic                        valid_ff, valid_in;
   logic                        is_error_ff, is_error_in;
   logic [7:0]                  value_ff, value_in;
   logic                        reset_seen_ff, reset_seen_in;
   logic                        last_ff, last_in;
   logic                        out_load;
   logic                        emit;
   logic [7:0]                  credit;
   logic [7:0]                  code;

   assign out_load = !valid_ff || rsp_ch.ready;
   assign emit     = out_load && !q_status.empty;
   assign k_next   = k_ff + cefd_pkg::CountW'(1);
   assign last_in  = (k_next == head.n_events);
   assign pop      = emit && last_in;

   assign credit = head.pairs[{k_ff, 1'b0}];
   assign code   = head.pairs[{k_ff, 1'b1}];

   always_comb begin
      if (head.reset_frame) begin
         is_error_in   = 1'b0;
         value_in      = 8'h00;
         reset_seen_in = 1'b1;
      end else begin
         is_error_in   = (credit == 8'h00);
         value_in      = (credit == 8'h00) ? code : credit;
         reset_seen_in = 1'b0;
      end
   end

   always_comb begin
      k_in     = k_ff;
      valid_in = valid_ff;
      if (emit) begin
         k_in     = last_in ? '0 : k_next;
         valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         k_ff     <= '0;
         valid_ff <= 1'b0;
      end else begin
         k_ff     <= k_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         is_error_ff   <= is_error_in;
         value_ff      <= value_in;
         reset_seen_ff <= reset_seen_in;
         last_ff       <= last_in;
      end
   end

   assign rsp_ch.valid       = valid_ff;
   assign rsp_ch.is_error    = is_error_ff;
   assign rsp_ch.value       = value_ff;
   assign rsp_ch.reset_seen  = reset_seen_ff;
   assign rsp_ch.last_of_run = last_ff;

   a_k_in_range: assert property (@(posedge clock) disable iff (reset)
      !q_status.empty |-> (k_ff < head.n_events))
      else $error("event index beyond job count");

   a_k_idle_zero: assert property (@(posedge clock) disable iff (reset)
      (k_ff != '0) |-> !q_status.empty)
      else $error("event index left over without a job");

   a_reset_job_single: assert property (@(posedge clock) disable iff (reset)
      (!q_status.empty && head.reset_frame) |-> (head.n_events == cefd_pkg::CountW'(1)))
      else $error("reset frame job with more than one event");

   a_pop_marks_last: assert property (@(posedge clock) disable iff (reset)
      pop |=> (valid_ff && last_ff))
      else $error("job retired without a last result");

endmodule

@@ design/credit_event_frame_decoder_unit.sv @@
// Top level of the credit event frame decoder: front, job queue and back.
// Depends on cefd_pkg, cefd_req_if, cefd_rsp_if, cefd_front, cefd_queue, cefd_back.
//
//   channel   dir  payload                                   handshake
//   req_ch    in   frame_byte[7:0], frame_end                valid/ready
//   rsp_ch    out  is_error, value[7:0], reset_seen,         valid/ready
//                  last_of_run
//
// One byte is taken per cycle; the front stalls only while the job queue is full.
// A finished frame yields 0 to 5 results, one per cycle from the back unless the
// receiver stalls, each passing through the result register; the queue holds two
// frames, so bytes of the next frame keep flowing while results drain.
// Reset (synchronous, active high) clears counter, reset flag, byte offset and queue.
// A stalled result holds in the output register while the front carries on.
module credit_event_frame_decoder_unit (
   input  logic       clock,
   input  logic       reset,
   cefd_req_if.sink   req_ch,
   cefd_rsp_if.source rsp_ch
);

   cefd_pkg::queue_status_type q_status;
   cefd_pkg::job_type          push_job;
   cefd_pkg::job_type          head;
   logic                       push;
   logic                       pop;

   // classify each frame and hand over a job at its end
   cefd_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_ch   (req_ch),
      .q_status (q_status),
      .push     (push),
      .push_job (push_job)
   );

   // hold jobs so the two sides stall independently
   cefd_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .head     (head),
      .q_status (q_status)
   );

   // advance through the head job, one result transfer per event
   cefd_back u_back (
      .clock    (clock),
      .reset    (reset),
      .head     (head),
      .q_status (q_status),
      .pop      (pop),
      .rsp_ch   (rsp_ch)
   );

endmodule

@@ sim/tb_credit_event_frame_decoder_unit.sv @@
`timescale 1ns / 1ps
// Testbench for credit_event_frame_decoder_unit: random byte frames in, decoded credit events out.
// Depends on cefd_pkg, cefd_req_if, cefd_rsp_if and the decoder RTL.
module tb_credit_event_frame_decoder_unit;

   localparam int IdleLimit   = 3000;  // cycles with no transfer on either side
   localparam int LongHoldOff = 400;   // one long receiver hold-off, fills the job queue
   localparam int DrainCycles = 20;    // quiet tail after the last owed result, to catch stray results

   // One byte transfer on the request side.
   typedef struct packed {
      logic [7:0] data;
      logic       fin;
   } frame_byte_type;

   // One decoded event on the result side.
   typedef struct packed {
      logic       is_error;
      logic [7:0] value;
      logic       reset_seen;
      logic       last_of_run;
   } credit_event_type;

   // Shapes of random frame.
   typedef enum int {
      FRM_REGULAR,     // 15 bytes, counter moves on by a few
      FRM_LONG,        // over-length, trailing bytes dropped by the block
      FRM_DEV_RESET,   // counter byte zero
      FRM_JUMP,        // counter anywhere, usually capped at the event limit
      FRM_NOISE        // random length and random counter
   } frame_kind_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   cefd_req_if req_if ();
   cefd_rsp_if rsp_if ();

   credit_event_frame_decoder_unit u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_if),
      .rsp_ch (rsp_if)
   );

   always #5 clock = ~clock;

   // Stimulus backlog, owed results and bookkeeping.
   frame_byte_type   byte_backlog[$];
   credit_event_type owed_events[$];
   int               bytes_made      = 0;
   int               bytes_taken     = 0;
   int               error_count     = 0;
   logic             req_taken       = 1'b0;

   // Decoder state as the predictor sees it.
   logic [7:0]                ev_count;
   logic                      rst_flag;
   logic [cefd_pkg::PosW-1:0] byte_pos;
   logic [7:0]                frame_bytes[cefd_pkg::StoreDepth];

   // ------------------------------------------------------------------
   // Predictor: fold one accepted byte into the state and queue whatever
   // events the byte releases (only a frame end releases any).
   // ------------------------------------------------------------------
   task automatic decode_frame_byte(input logic [7:0] data, input logic fin);
      int unsigned      new_cnt;
      int unsigned      n_ev;
      credit_event_type ev;
      // clear the store on the first byte of every frame
      if (byte_pos == 0) begin
         foreach (frame_bytes[i]) frame_bytes[i] = 8'h00;
      end
      if (byte_pos >= cefd_pkg::StoreBase &&
          byte_pos < cefd_pkg::StoreBase + cefd_pkg::StoreDepth) begin
         frame_bytes[byte_pos - cefd_pkg::StoreBase] = data;
      end
      // saturate the offset so that over-length frames stay parked
      if (byte_pos != cefd_pkg::PosMax) byte_pos = byte_pos + 1'b1;
      if (!fin) return;

      byte_pos = '0;
      new_cnt  = frame_bytes[0];
      n_ev     = 0;

      // counter back to zero: device reset if we had a count, silent otherwise
      if (new_cnt == 0) begin
         if (ev_count != 0) begin
            ev_count = 8'h00;
            rst_flag = 1'b1;
            ev = '{is_error: 1'b0, value: 8'h00, reset_seen: 1'b1, last_of_run: 1'b1};
            owed_events.push_back(ev);
         end
         return;
      end

      if (ev_count == 0) begin
         // take the full count only after a device reset; start-up polls give nothing
         if (rst_flag) begin
            n_ev     = new_cnt;
            rst_flag = 1'b0;
         end
      end else if (ev_count < new_cnt) begin
         n_ev = new_cnt - ev_count;
      end else if (ev_count > new_cnt) begin
         // wrap skips zero, hence 255 rather than 256
         n_ev = 255 - ev_count + new_cnt;
      end
      if (n_ev > cefd_pkg::MaxEvents) n_ev = cefd_pkg::MaxEvents;
      ev_count = new_cnt[7:0];

      for (int k = 0; k < n_ev; k++) begin
         ev.reset_seen  = 1'b0;
         ev.last_of_run = (k + 1 == n_ev);
         if (frame_bytes[1 + 2 * k] != 8'h00) begin
            ev.is_error = 1'b0;
            ev.value    = frame_bytes[1 + 2 * k];
         end else begin
            ev.is_error = 1'b1;
            ev.value    = frame_bytes[2 + 2 * k];
         end
         owed_events.push_back(ev);
      end
   endtask

   // Report one mismatch and count it.
   task automatic flag_mismatch(input string what);
      $display("%0t ns  MISMATCH  %s", $time, what);
      error_count++;
   endtask

   // Queue one frame of n_bytes bytes; odd offsets past the counter carry credits,
   // zero_pct of them zero so that the error code path is taken.
   task automatic push_frame(input int n_bytes, input logic [7:0] counter, input int zero_pct);
      frame_byte_type item;
      for (int i = 0; i < n_bytes; i++) begin
         if (i == cefd_pkg::StoreBase) begin
            item.data = counter;
         end else if (i > cefd_pkg::StoreBase &&
                      i < cefd_pkg::StoreBase + cefd_pkg::StoreDepth &&
                      (i - cefd_pkg::StoreBase) % 2 == 1) begin
            item.data = ($urandom_range(0, 99) < zero_pct) ? 8'h00 : 8'($urandom_range(1, 255));
         end else begin
            item.data = 8'($urandom);
         end
         item.fin = (i == n_bytes - 1);
         byte_backlog.push_back(item);
      end
      bytes_made += n_bytes;
   endtask

   // ------------------------------------------------------------------
   // Monitor: sample both channels at the rising edge, predict on every
   // byte transfer and check every result transfer against the oldest owed.
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      credit_event_type exp;
      if (reset) begin
         ev_count  = 8'h00;
         rst_flag  = 1'b0;
         byte_pos  = '0;
         foreach (frame_bytes[i]) frame_bytes[i] = 8'h00;
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_if.valid && req_if.ready;
         if (req_if.valid && req_if.ready) begin
            decode_frame_byte(req_if.frame_byte, req_if.frame_end);
            bytes_taken++;
         end
         if (rsp_if.valid && rsp_if.ready) begin
            if (owed_events.size() == 0) begin
               flag_mismatch($sformatf("unowed result: err %0b value %02h rst %0b last %0b",
                                       rsp_if.is_error, rsp_if.value, rsp_if.reset_seen,
                                       rsp_if.last_of_run));
            end else begin
               exp = owed_events.pop_front();
               if (rsp_if.is_error !== exp.is_error)
                  flag_mismatch($sformatf("is_error %0b, want %0b", rsp_if.is_error,
                                          exp.is_error));
               if (rsp_if.value !== exp.value)
                  flag_mismatch($sformatf("value %02h, want %02h", rsp_if.value, exp.value));
               if (rsp_if.reset_seen !== exp.reset_seen)
                  flag_mismatch($sformatf("reset_seen %0b, want %0b", rsp_if.reset_seen,
                                          exp.reset_seen));
               if (rsp_if.last_of_run !== exp.last_of_run)
                  flag_mismatch($sformatf("last_of_run %0b, want %0b", rsp_if.last_of_run,
                                          exp.last_of_run));
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Byte driver: bursts of random length with random gaps between them.
   // Advance only once the byte on the bus has been transferred.
   // ------------------------------------------------------------------
   int burst_left = 1;
   int gap_left   = 0;

   always @(negedge clock) begin
      frame_byte_type item;
      if (reset) begin
         req_if.valid <= 1'b0;
      end else if (!req_if.valid || req_taken) begin
         if (gap_left > 0) begin
            gap_left--;
            req_if.valid <= 1'b0;
         end else if (byte_backlog.size() > 0) begin
            item = byte_backlog.pop_front();
            req_if.valid      <= 1'b1;
            req_if.frame_byte <= item.data;
            req_if.frame_end  <= item.fin;
            burst_left--;
            if (burst_left <= 0) begin
               burst_left = $urandom_range(1, 12);
               // roughly one burst in four runs straight into the next
               gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            end
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   // ------------------------------------------------------------------
   // Result receiver: rotating stall pattern, redrawn whenever its age runs out,
   // plus one long hold-off partway through so the job queue fills and
   // the front stalls the byte stream.
   // ------------------------------------------------------------------
   logic [7:0] ready_pat  = 8'hFF;
   int         pat_age    = 0;
   int         hold_left  = 0;
   logic       hold_done  = 1'b0;

   always @(negedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (!hold_done && bytes_taken >= 120) begin
            hold_done = 1'b1;
            hold_left = LongHoldOff;
         end
         if (pat_age == 0) begin
            // a quarter of the windows never stall
            ready_pat = ($urandom_range(0, 3) == 0) ? 8'hFF : 8'($urandom);
            pat_age   = 48;
         end
         pat_age--;
         if (hold_left > 0) begin
            hold_left--;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= ready_pat[0];
         end
         ready_pat = {ready_pat[0], ready_pat[7:1]};
      end
   end

   // ------------------------------------------------------------------
   // Watchdog: count cycles with no transfer on either side.
   // ------------------------------------------------------------------
   int idle_cycles = 0;

   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IdleLimit) begin
         $display("%0t ns  watchdog: no transfer for %0d cycles", $time, IdleLimit);
         $display("tb_credit_event_frame_decoder_unit: done, errors");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // ------------------------------------------------------------------
   // Stimulus and end of run.
   // ------------------------------------------------------------------
   initial begin
      frame_kind_type kind;
      int             pick;
      int             len;
      int             nxt;
      logic [7:0]     gen_cnt;

      // hold every block input at a known value from time zero
      req_if.valid      = 1'b0;
      req_if.frame_byte = 8'h00;
      req_if.frame_end  = 1'b0;
      rsp_if.ready      = 1'b0;

      // Directed opening: fill the backlog before reset drops.
      push_frame(1, 8'h00, 0);    // one-byte frame: counter reads zero, count still zero
      push_frame(5, 8'hFF, 0);    // first poll after start-up: counter taken, no events
      push_frame(7, 8'h02, 100);  // wrap past 255 skipping zero; zero credit, missing pair
      push_frame(1, 8'h00, 0);    // counter drops to zero: device reset reported
      push_frame(5, 8'hFF, 0);    // full count after reset, capped at the limit
      push_frame(7, 8'h03, 0);    // wrap again, one real credit then missing pairs
      gen_cnt = 8'h03;

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Random part: mostly well-formed frames whose counter moves on sensibly,
      // the rest resets, jumps, over-length frames and noise.
      while (bytes_made < 350) begin
         while (byte_backlog.size() > 40) @(posedge clock);
         pick = $urandom_range(0, 99);
         kind = (pick < 55) ? FRM_REGULAR   :
                (pick < 67) ? FRM_LONG      :
                (pick < 77) ? FRM_DEV_RESET :
                (pick < 89) ? FRM_JUMP      : FRM_NOISE;
         case (kind)
            FRM_REGULAR, FRM_LONG: begin
               nxt = gen_cnt + $urandom_range(0, 7);
               if (nxt > 255) nxt -= 255;
               len = (kind == FRM_LONG) ? $urandom_range(16, 22) : 15;
               push_frame(len, 8'(nxt), 25);
               gen_cnt = 8'(nxt);
            end
            FRM_DEV_RESET: begin
               // short frames read the counter as zero as well
               len = ($urandom_range(0, 1) == 0) ? $urandom_range(1, 4) : 15;
               push_frame(len, 8'h00, 25);
               gen_cnt = 8'h00;
            end
            FRM_JUMP: begin
               nxt = $urandom_range(1, 255);
               push_frame(15, 8'(nxt), 25);
               gen_cnt = 8'(nxt);
            end
            default: begin
               len = $urandom_range(1, 20);
               nxt = $urandom_range(0, 255);
               push_frame(len, 8'(nxt), 50);
               gen_cnt = (len > cefd_pkg::StoreBase) ? 8'(nxt) : 8'h00;
            end
         endcase
      end

      // drain: every byte transferred, every owed event seen, then a short tail
      while (bytes_taken < bytes_made) @(posedge clock);
      while (owed_events.size() > 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);

      if (error_count == 0) begin
         $display("tb_credit_event_frame_decoder_unit: done, clean");
      end else begin
         $display("tb_credit_event_frame_decoder_unit: done, errors");
      end
      $finish;
   end

endmodule
